>>> src/assert_macros.svh
// assertion macros shared by the capture unit rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> src/octc_pkg.sv
// shared types, constants and float-bit helpers of the capture unit
// no dependencies
package octc_pkg;

   // capture store size in frames
   localparam int MAX_FRAMES = 65536;

   localparam int POS_W     = 53;
   localparam int CNT_W     = 17;
   localparam int SMP_W     = 32;
   localparam int CH_W      = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 17;

   // store is split in two banks by the parity of the interleaved index
   localparam int NUM_BANKS  = 2;
   localparam int BANK_DEPTH = MAX_FRAMES;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   localparam logic [CNT_W-1:0] MAX_CNT      = CNT_W'(MAX_FRAMES);
   localparam logic [CNT_W-1:0] TARGET_RESET = CNT_W'(65536);

   // channel count codes; three behaves as stereo
   localparam logic [CH_W-1:0] CH_OFF    = 2'd0;
   localparam logic [CH_W-1:0] CH_MONO   = 2'd1;
   localparam logic [CH_W-1:0] CH_STEREO = 2'd2;

   // float magnitude limits: infinity and 1.0e-7f
   localparam logic [SMP_W-2:0] INF_MAG    = 31'h7F80_0000;
   localparam logic [SMP_W-2:0] THRESH_MAG = 31'h33D6_BF95;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TARGET_FRAMES = 2'd0,
      REG_CHANNEL_COUNT = 2'd1
   } reg_index_type;

   typedef struct packed {
      logic [POS_W-1:0] frame_position;
      logic [SMP_W-1:0] sample_left;
      logic [SMP_W-1:0] sample_right;
      logic             break_marker;
   } frame_type;

   typedef struct packed {
      logic [POS_W-1:0] capture_start;
      logic [CNT_W-1:0] captured_count;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0] target_frames;
      logic [CH_W-1:0]  channel_count;
   } cfg_type;

   typedef struct packed {
      logic               en;
      logic [BANK_AW-1:0] addr;
      logic [SMP_W-1:0]   data;
   } bank_wr_type;

   function automatic logic is_finite(input logic [SMP_W-1:0] b);
      return b[SMP_W-2:0] < INF_MAG;
   endfunction

   function automatic logic is_active(input logic [SMP_W-1:0] b);
      return (b[SMP_W-2:0] < INF_MAG) && (b[SMP_W-2:0] >= THRESH_MAG);
   endfunction

endpackage

>>> src/octc_if.sv
// valid/ready channel interfaces of the capture unit: frames, results, csr writes
// depends on octc_pkg
interface octc_req_if;
   import octc_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] frame_position;
   logic [SMP_W-1:0] sample_left;
   logic [SMP_W-1:0] sample_right;
   logic             break_marker;

   modport source (output valid, frame_position, sample_left, sample_right, break_marker,
                   input ready);
   modport sink (input valid, frame_position, sample_left, sample_right, break_marker,
                 output ready);
endinterface

interface octc_rsp_if;
   import octc_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] capture_start;
   logic [CNT_W-1:0] captured_count;

   modport source (output valid, capture_start, captured_count, input ready);
   modport sink (input valid, capture_start, captured_count, output ready);
endinterface

interface octc_csr_if;
   import octc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> src/onset_triggered_contiguous_capture_unit.sv
// top level of the onset-triggered contiguous capture unit
// depends on octc_pkg, octc_if, octc_ram, octc_ctrl, octc_outq, assert_macros.svh
//
//   channel | dir | payload                                            | handshake
//   --------+-----+----------------------------------------------------+----------
//   req     | in  | frame_position, sample_left, sample_right, break   | valid/ready
//   rsp     | out | capture_start, captured_count                      | valid/ready
//   csr     | in  | index (0 target_frames, 1 channel_count), data     | valid/ready
//
// one frame item per clock while req.ready is high: state update and store write
// complete in the accept cycle, the result (if any) shows on rsp in the next cycle
// from the output register, or from the skid stage once the result ahead is taken
// req.ready drops only while both the output register and the skid stage hold results
// csr.ready is always high; writes take effect in the next cycle
// synchronous active-high reset clears control state; the store is not cleared
`include "assert_macros.svh"

module onset_triggered_contiguous_capture_unit (
   input logic        clock,
   input logic        reset,
   octc_req_if.sink   req,
   octc_rsp_if.source rsp,
   octc_csr_if.sink   csr
);
   import octc_pkg::*;

   // configuration registers
   logic [CNT_W-1:0] target_ff, target_in;
   logic [CH_W-1:0]  chans_ff, chans_in;
   cfg_type          cfg;

   frame_type   frame;
   logic        fire;
   logic        q_ready;
   logic        res_valid;
   result_type  res;
   bank_wr_type wr [NUM_BANKS];

   assign csr.ready = 1'b1;

   always_comb begin
      target_in = target_ff;
      chans_in  = chans_ff;
      if (csr.valid) begin
         unique case (reg_index_type'(csr.index))
            REG_TARGET_FRAMES: target_in = csr.data[CNT_W-1:0];
            REG_CHANNEL_COUNT: chans_in  = csr.data[CH_W-1:0];
            default:           target_in = target_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
         chans_ff  <= CH_STEREO;
      end else begin
         target_ff <= target_in;
         chans_ff  <= chans_in;
      end
   end

   assign cfg.target_frames = target_ff;
   assign cfg.channel_count = chans_ff;

   // frame intake; held off only while results back up
   assign req.ready = q_ready;
   assign fire      = req.valid && q_ready;

   assign frame.frame_position = req.frame_position;
   assign frame.sample_left    = req.sample_left;
   assign frame.sample_right   = req.sample_right;
   assign frame.break_marker   = req.break_marker;

   octc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .frame     (frame),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res),
      .wr        (wr)
   );

   octc_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .ready     (q_ready),
      .rsp       (rsp)
   );

   // sample store: two banks, each written at most once per frame.
   // the read port replays the last written row as a readback check
   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic               chk_valid_ff;
      logic [BANK_AW-1:0] chk_addr_ff;
      logic [SMP_W-1:0]   chk_data_ff;
      logic               chk2_valid_ff;
      logic [SMP_W-1:0]   chk2_data_ff;
      logic [SMP_W-1:0]   rdata;

      octc_ram #(
         .WIDTH (SMP_W),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock (clock),
         .we    (wr[b].en),
         .waddr (wr[b].addr),
         .wdata (wr[b].data),
         .raddr (chk_addr_ff),
         .rdata (rdata)
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            chk_valid_ff  <= 1'b0;
            chk2_valid_ff <= 1'b0;
         end else begin
            chk_valid_ff  <= wr[b].en;
            chk2_valid_ff <= chk_valid_ff;
         end
         if (wr[b].en) begin
            chk_addr_ff <= wr[b].addr;
         end
         chk_data_ff  <= wr[b].data;
         chk2_data_ff <= chk_data_ff;
      end

      `ASSERT_IMPLIES(a_readback, clock, reset, chk2_valid_ff, rdata == chk2_data_ff)
   end

endmodule

>>> src/octc_ram.sv
// generic single-port-write ram with one registered read port
// no dependencies
module octc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/octc_ctrl.sv
// capture control: onset detect, continuity tracking, frame counting, store writes
// depends on octc_pkg and assert_macros.svh
`include "assert_macros.svh"

module octc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  octc_pkg::frame_type frame,
   input  octc_pkg::cfg_type   cfg,
   output logic                res_valid,
   output octc_pkg::result_type res,
   output octc_pkg::bank_wr_type wr [octc_pkg::NUM_BANKS]
);
   import octc_pkg::*;

   logic             collecting_ff, collecting_in;
   logic             done_ff, done_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic [CNT_W-1:0] stored_ff, stored_in;
   logic [POS_W-1:0] expect_ff, expect_in;

   // state after an optional break
   logic             brk;
   logic             collecting_c, done_c, idle;
   logic [POS_W-1:0] start_c, expect_c, start_eff, expect_eff, pos_next;
   logic [CNT_W-1:0] stored_c, target_eff, count_next;
   logic             use_left, use_right, content, bad_sample;
   logic             pos_match, storing, complete, store_en;

   assign brk          = frame.break_marker;
   assign collecting_c = collecting_ff && !brk;
   assign done_c       = done_ff && !brk;
   assign start_c      = brk ? '0 : start_ff;
   assign stored_c     = brk ? '0 : stored_ff;
   assign expect_c     = brk ? '0 : expect_ff;
   assign idle         = !collecting_c && !done_c;

   assign target_eff = (cfg.target_frames > MAX_CNT) ? MAX_CNT : cfg.target_frames;
   assign use_left   = cfg.channel_count != CH_OFF;
   assign use_right  = (cfg.channel_count != CH_OFF) && (cfg.channel_count != CH_MONO);

   assign content    = (use_left && is_active(frame.sample_left)) ||
                       (use_right && is_active(frame.sample_right));
   assign bad_sample = (use_left && !is_finite(frame.sample_left)) ||
                       (use_right && !is_finite(frame.sample_right));

   // a capture starting on this frame begins here
   assign start_eff  = idle ? frame.frame_position : start_c;
   assign expect_eff = idle ? frame.frame_position : expect_c;
   assign pos_match  = frame.frame_position == expect_eff;
   assign pos_next   = frame.frame_position + POS_W'(1);

   assign storing    = stored_c < target_eff;
   assign count_next = storing ? (stored_c + CNT_W'(1)) : target_eff;
   assign complete   = count_next == target_eff;

   always_comb begin
      collecting_in = collecting_ff;
      done_in       = done_ff;
      start_in      = start_ff;
      stored_in     = stored_ff;
      expect_in     = expect_ff;
      res_valid     = 1'b0;
      store_en      = 1'b0;
      if (fire) begin
         priority if (idle && !content) begin
            collecting_in = collecting_c;
            done_in       = done_c;
            start_in      = start_c;
            stored_in     = stored_c;
            expect_in     = expect_c;
         end else if (!pos_match || (!done_c && storing && bad_sample) ||
                      (!done_c && !storing && (target_eff == '0))) begin
            // gap, bad sample or empty target
            collecting_in = 1'b0;
            done_in       = 1'b0;
            start_in      = '0;
            stored_in     = '0;
            expect_in     = '0;
         end else if (done_c) begin
            expect_in = pos_next;
         end else begin
            collecting_in = !complete;
            done_in       = complete;
            start_in      = start_eff;
            stored_in     = count_next;
            expect_in     = pos_next;
            res_valid     = complete;
            store_en      = storing;
         end
      end
   end

   assign res.capture_start  = start_eff;
   assign res.captured_count = count_next;

   // stereo: left to even bank, right to odd bank, same row
   // mono: left goes to the bank picked by the count parity
   always_comb begin
      wr[0].en   = store_en && (use_right || (use_left && !stored_c[0]));
      wr[0].addr = use_right ? BANK_AW'(stored_c) : BANK_AW'(stored_c >> 1);
      wr[0].data = frame.sample_left;
      wr[1].en   = store_en && (use_right || (use_left && stored_c[0]));
      wr[1].addr = wr[0].addr;
      wr[1].data = use_right ? frame.sample_right : frame.sample_left;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         done_ff       <= 1'b0;
         start_ff      <= '0;
         stored_ff     <= '0;
         expect_ff     <= '0;
      end else begin
         collecting_ff <= collecting_in;
         done_ff       <= done_in;
         start_ff      <= start_in;
         stored_ff     <= stored_in;
         expect_ff     <= expect_in;
      end
   end

   `ASSERT_IMPLIES(a_flags_excl, clock, reset, collecting_ff, !done_ff)
   `ASSERT_NEXT(a_done_after_result, clock, reset, res_valid, done_ff && !collecting_ff)

endmodule

>>> src/octc_outq.sv
// result output register with a one-entry skid stage
// depends on octc_pkg, octc_if and assert_macros.svh
`include "assert_macros.svh"

module octc_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  octc_pkg::result_type push_data,
   output logic                 ready,
   octc_rsp_if.source           rsp
);
   import octc_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop   = out_valid_ff && rsp.ready;
   assign ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end else begin
         skid_valid_in = skid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.capture_start  = out_data_ff.capture_start;
   assign rsp.captured_count = out_data_ff.captured_count;

   `ASSERT_NEXT(a_skid_drain, clock, reset, skid_valid_ff && rsp.ready, out_valid_ff)

endmodule
